// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define KSF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define KSF_ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define KSF_ASSERT(lbl, prop, msg)
`define KSF_ASSERT_IMPL(lbl, pre, post, msg)
`endif

`endif

// ----- rtl/ksf_pkg.sv -----
// ----------------------------------------------------------------------------
// ksf_pkg
// Shared types and constants of the spanning forest block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ksf_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 256;
    localparam int DEF_COST_BITS    = 32;

    localparam int END_BITS   = 6;
    localparam int VCNT_BITS  = 7;
    localparam logic [VCNT_BITS-1:0] VCNT_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_FIND_A,
        ST_FIND_B,
        ST_JOIN,
        ST_FINISH
    } ksf_state_t;

    typedef struct packed {
        logic                clear;
        logic                start;
        logic [END_BITS-1:0] vertex;
        logic                link;
        logic [END_BITS-1:0] link_from;
        logic [END_BITS-1:0] link_to;
    } uf_ctl_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [END_BITS-1:0] root;
    } uf_stat_t;

endpackage

// ----- rtl/ksf_ifs.sv -----
// ----------------------------------------------------------------------------
// ksf_ifs
// Valid/ready channels: edge input, tree output, configuration write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ksf_edge_if
    import ksf_pkg::*;
#(
    parameter int COST_BITS = DEF_COST_BITS
);
    logic                 valid;
    logic                 ready;
    logic [END_BITS-1:0]  end_a;
    logic [END_BITS-1:0]  end_b;
    logic [COST_BITS-1:0] edge_cost;
    logic                 last_edge;

    modport source (output valid, end_a, end_b, edge_cost, last_edge, input ready);
    modport sink   (input valid, end_a, end_b, edge_cost, last_edge, output ready);
endinterface

interface ksf_tree_if
    import ksf_pkg::*;
#(
    parameter int COST_BITS = DEF_COST_BITS
);
    logic                 valid;
    logic                 ready;
    logic [END_BITS-1:0]  tree_a;
    logic [END_BITS-1:0]  tree_b;
    logic [COST_BITS-1:0] tree_cost;
    logic                 edge_valid;
    logic                 final_result;
    logic                 dropped_flag;

    modport source (output valid, tree_a, tree_b, tree_cost, edge_valid, final_result,
                    dropped_flag, input ready);
    modport sink   (input valid, tree_a, tree_b, tree_cost, edge_valid, final_result,
                    dropped_flag, output ready);
endinterface

interface ksf_cfg_if
    import ksf_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [VCNT_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/ksf_find.sv -----
// ----------------------------------------------------------------------------
// ksf_find
// Union-find parent store with an iterative root walk, one step a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ksf_find
    import ksf_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
)(
    input  logic     clk,
    input  logic     rst_n,
    input  uf_ctl_t  ctl,
    output uf_stat_t stat
);

    localparam int VW = $clog2(MAX_VERTICES);

    logic [VW-1:0]           parent_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] set_reg;
    logic                    busy_reg;
    logic [VW-1:0]           cur_reg;
    logic [VW-1:0]           rd_q_reg;
    logic                    rd_set_reg;

    logic [VW-1:0] parent;
    logic          at_root;
    logic          rd_en;
    logic [VW-1:0] rd_addr;

    // an entry never linked since the last clear is its own parent
    assign parent  = rd_set_reg ? rd_q_reg : cur_reg;
    assign at_root = (parent == cur_reg);
    assign rd_en   = ctl.start || (busy_reg && !at_root);
    assign rd_addr = ctl.start ? ctl.vertex[VW-1:0] : parent;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_q_reg <= parent_mem[rd_addr];
        end
        if (ctl.link)
        begin
            parent_mem[ctl.link_from[VW-1:0]] <= ctl.link_to[VW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_reg    <= '0;
            busy_reg   <= 1'b0;
            cur_reg    <= '0;
            rd_set_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                set_reg <= '0;
            end
            else if (ctl.link)
            begin
                set_reg[ctl.link_from[VW-1:0]] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_set_reg <= set_reg[rd_addr];
                cur_reg    <= rd_addr;
            end
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && at_root)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && at_root;
    assign stat.root = END_BITS'(cur_reg);

endmodule

// ----- rtl/kruskal_spanning_forest.sv -----
// ----------------------------------------------------------------------------
// kruskal_spanning_forest
// Minimum spanning forest of a weighted graph streamed in edge by edge.
// ----------------------------------------------------------------------------
//   edge_in  : one edge per item; edges with both endpoints below vertex_count
//              are stored up to MAX_EDGES, others dropped and flagged. An item
//              with last_edge set starts a run.
//   tree_out : chosen edges by ascending cost (ties in arrival order), the last
//              with final_result set; an empty forest gives one item with
//              edge_valid low. dropped_flag reports drops.
//   cfg      : writes vertex_count; always ready, write only while idle.
//   Edges load while the block is idle. A run is a series of passes over the N
//   stored edges through the key comparison, each picking the next edge in
//   sort order; each endpoint then walks to its root, and a joined edge passes
//   through the join state. edge_in is not ready while a run is in progress.
// Reset clears the edge count, the drop flag and all sets, and sets
// vertex_count to 64. A stalled tree_out holds its item; the run waits once
// a chosen edge is pending and the output register is still full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kruskal_spanning_forest
    import ksf_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES,
    parameter int COST_BITS    = DEF_COST_BITS
)(
    input  logic      clk,
    input  logic      rst_n,
    ksf_edge_if.sink  edge_in,
    ksf_tree_if.source tree_out,
    ksf_cfg_if.sink   cfg
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int IW = $clog2(MAX_EDGES);
    localparam int CW = IW + 1;
    localparam int EW = 2 * VW + COST_BITS;
    localparam int KW = COST_BITS + IW;
    localparam logic [VCNT_BITS-1:0] VMAX = VCNT_BITS'(MAX_VERTICES);
    localparam logic [VW-1:0] LAST_CNT = VW'(MAX_VERTICES - 2);

    ksf_state_t state_reg, state_next;

    // configuration
    logic [VCNT_BITS-1:0] vcount_reg;
    logic [VCNT_BITS-1:0] limit;

    // edge store and load control
    logic [EW-1:0] edge_mem [MAX_EDGES];
    logic [CW-1:0] total_reg;
    logic          drop_reg;
    logic          flag_reg;

    // scan pass
    logic [CW-1:0]        scan_idx_reg;
    logic                 rd_v_reg;
    logic [IW-1:0]        rd_idx_reg;
    logic [EW-1:0]        rd_q_reg;
    logic                 best_v_reg;
    logic [KW-1:0]        best_key_reg;
    logic [VW-1:0]        best_a_reg;
    logic [VW-1:0]        best_b_reg;
    logic                 have_prev_reg;
    logic [KW-1:0]        prev_key_reg;

    // run bookkeeping
    logic [END_BITS-1:0]  root_a_reg;
    logic [VW-1:0]        cnt_reg;
    logic                 pend_v_reg;
    logic [VW-1:0]        pend_a_reg;
    logic [VW-1:0]        pend_b_reg;
    logic [COST_BITS-1:0] pend_cost_reg;

    // output register
    logic                 out_v_reg;
    logic [VW-1:0]        out_a_reg;
    logic [VW-1:0]        out_b_reg;
    logic [COST_BITS-1:0] out_cost_reg;
    logic                 out_ev_reg;
    logic                 out_fin_reg;
    logic                 out_drop_reg;

    uf_ctl_t  uf_ctl;
    uf_stat_t uf_stat;

    logic          in_acc;
    logic          bad_edge;
    logic          store_en;
    logic          scan_issue;
    logic          scan_done;
    logic [KW-1:0] cand_key;
    logic          cand_ok;
    logic          out_free;

    // control strobes
    logic start_run;
    logic scan_rst;
    logic take_best;
    logic take_a;
    logic do_link;
    logic join_go;
    logic finish_go;

    assign limit    = (vcount_reg > VMAX) ? VMAX : vcount_reg;
    assign in_acc   = edge_in.valid && edge_in.ready;
    assign bad_edge = ({1'b0, edge_in.end_a} >= limit) || ({1'b0, edge_in.end_b} >= limit)
                      || (total_reg == CW'(MAX_EDGES));
    assign store_en = in_acc && !bad_edge;

    assign edge_in.ready = (state_reg == ST_LOAD);
    assign cfg.ready     = 1'b1;
    assign out_free      = !out_v_reg || tree_out.ready;

    // scan: stream the store through the comparator, key is cost then index
    assign scan_issue = (state_reg == ST_SCAN) && (scan_idx_reg < total_reg);
    assign scan_done  = (state_reg == ST_SCAN) && (scan_idx_reg == total_reg) && !rd_v_reg;
    assign cand_key   = {rd_q_reg[COST_BITS-1:0], rd_idx_reg};
    assign cand_ok    = (!have_prev_reg || (cand_key > prev_key_reg))
                        && (!best_v_reg || (cand_key < best_key_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc && edge_in.last_edge)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = best_v_reg ? ST_FIND_A : ST_FINISH;
                end
            end
            ST_FIND_A:
            begin
                if (uf_stat.done)
                begin
                    state_next = ST_FIND_B;
                end
            end
            ST_FIND_B:
            begin
                if (uf_stat.done)
                begin
                    state_next = (uf_stat.root == root_a_reg) ? ST_SCAN : ST_JOIN;
                end
            end
            ST_JOIN:
            begin
                if (!pend_v_reg || out_free)
                begin
                    state_next = (cnt_reg == LAST_CNT) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // strobes and union-find requests
    always_comb
    begin
        start_run = 1'b0;
        scan_rst  = 1'b0;
        take_best = 1'b0;
        take_a    = 1'b0;
        do_link   = 1'b0;
        join_go   = 1'b0;
        finish_go = 1'b0;
        uf_ctl    = '0;
        unique case (state_reg)
            ST_LOAD:
            begin
                start_run = in_acc && edge_in.last_edge;
                scan_rst  = start_run;
            end
            ST_SCAN:
            begin
                take_best     = scan_done && best_v_reg;
                uf_ctl.start  = take_best;
                uf_ctl.vertex = END_BITS'(best_a_reg);
            end
            ST_FIND_A:
            begin
                take_a        = uf_stat.done;
                uf_ctl.start  = uf_stat.done;
                uf_ctl.vertex = END_BITS'(best_b_reg);
            end
            ST_FIND_B:
            begin
                if (uf_stat.done)
                begin
                    do_link  = (uf_stat.root != root_a_reg);
                    scan_rst = !do_link;
                end
            end
            ST_JOIN:
            begin
                join_go  = !pend_v_reg || out_free;
                scan_rst = join_go;
            end
            ST_FINISH:
            begin
                finish_go = out_free;
            end
            default:
            begin
            end
        endcase
        uf_ctl.clear     = start_run;
        uf_ctl.link      = do_link;
        uf_ctl.link_from = root_a_reg;
        uf_ctl.link_to   = uf_stat.root;
    end

    ksf_find #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_find (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (uf_ctl),
        .stat  (uf_stat)
    );

    // edge store: written at the fill count, read by the scan
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            edge_mem[total_reg[IW-1:0]] <= {edge_in.end_a[VW-1:0], edge_in.end_b[VW-1:0],
                                            edge_in.edge_cost};
        end
        if (scan_issue)
        begin
            rd_q_reg <= edge_mem[scan_idx_reg[IW-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (scan_issue)
        begin
            rd_idx_reg <= scan_idx_reg[IW-1:0];
        end
        if (rd_v_reg && cand_ok)
        begin
            best_key_reg <= cand_key;
            best_a_reg   <= rd_q_reg[EW-1 -: VW];
            best_b_reg   <= rd_q_reg[COST_BITS +: VW];
        end
        if (take_best)
        begin
            prev_key_reg <= best_key_reg;
        end
        if (take_a)
        begin
            root_a_reg <= uf_stat.root;
        end
        if (start_run)
        begin
            flag_reg <= drop_reg || bad_edge;
        end
        if (join_go)
        begin
            pend_a_reg    <= best_a_reg;
            pend_b_reg    <= best_b_reg;
            pend_cost_reg <= best_key_reg[KW-1 -: COST_BITS];
        end
        if (join_go && pend_v_reg)
        begin
            out_a_reg    <= pend_a_reg;
            out_b_reg    <= pend_b_reg;
            out_cost_reg <= pend_cost_reg;
            out_ev_reg   <= 1'b1;
            out_fin_reg  <= 1'b0;
            out_drop_reg <= flag_reg;
        end
        else if (finish_go)
        begin
            // empty forest gives a zero item with edge_valid low
            out_a_reg    <= pend_v_reg ? pend_a_reg : '0;
            out_b_reg    <= pend_v_reg ? pend_b_reg : '0;
            out_cost_reg <= pend_v_reg ? pend_cost_reg : '0;
            out_ev_reg   <= pend_v_reg;
            out_fin_reg  <= 1'b1;
            out_drop_reg <= flag_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            vcount_reg    <= VCNT_RESET;
            total_reg     <= '0;
            drop_reg      <= 1'b0;
            scan_idx_reg  <= '0;
            rd_v_reg      <= 1'b0;
            best_v_reg    <= 1'b0;
            have_prev_reg <= 1'b0;
            cnt_reg       <= '0;
            pend_v_reg    <= 1'b0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                vcount_reg <= cfg.data;
            end

            // load: count stored edges, remember any drop
            if (store_en)
            begin
                total_reg <= total_reg + CW'(1);
            end
            if (in_acc && bad_edge)
            begin
                drop_reg <= 1'b1;
            end

            // scan pass
            rd_v_reg <= scan_issue;
            if (scan_rst)
            begin
                scan_idx_reg <= '0;
                best_v_reg   <= 1'b0;
            end
            else
            begin
                if (scan_issue)
                begin
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                end
                if (rd_v_reg && cand_ok)
                begin
                    best_v_reg <= 1'b1;
                end
            end
            if (take_best)
            begin
                have_prev_reg <= 1'b1;
            end

            // chosen edge: hold it until the next one shows which is last
            if (join_go)
            begin
                pend_v_reg <= 1'b1;
                cnt_reg    <= cnt_reg + VW'(1);
            end

            // output register
            if ((join_go && pend_v_reg) || finish_go)
            begin
                out_v_reg <= 1'b1;
            end
            else if (tree_out.ready)
            begin
                out_v_reg <= 1'b0;
            end

            // end of run: empty the store for the next graph
            if (finish_go)
            begin
                pend_v_reg    <= 1'b0;
                cnt_reg       <= '0;
                have_prev_reg <= 1'b0;
                total_reg     <= '0;
                drop_reg      <= 1'b0;
            end
        end
    end

    assign tree_out.valid        = out_v_reg;
    assign tree_out.tree_a       = END_BITS'(out_a_reg);
    assign tree_out.tree_b       = END_BITS'(out_b_reg);
    assign tree_out.tree_cost    = out_cost_reg;
    assign tree_out.edge_valid   = out_ev_reg;
    assign tree_out.final_result = out_fin_reg;
    assign tree_out.dropped_flag = out_drop_reg;

    // no root walk runs while edges load
    `KSF_ASSERT_IMPL(a_idle_no_walk, state_reg == ST_LOAD, !uf_stat.busy, "walk during load")
    // nothing held back from a run once the block is back to loading
    `KSF_ASSERT_IMPL(a_idle_no_pend, state_reg == ST_LOAD, !pend_v_reg && cnt_reg == '0,
                     "run state left over")
    // the fill count never passes the store depth
    `KSF_ASSERT(a_total_bound, total_reg <= CW'(MAX_EDGES), "edge count overflow")
    // a link is only requested as the second root walk ends
    `KSF_ASSERT_IMPL(a_link_roots, do_link, uf_stat.done && state_reg == ST_FIND_B,
                     "link outside root compare")

endmodule
